/* rtl/wsd_pkg.sv */
// wsd_pkg: shared types and constants for the websocket frame decoder
// no dependencies; imported by wsd_parser, wsd_out_reg and websocket_frame_decoder
`timescale 1ns / 1ps

package wsd_pkg;

    // frame parse phases
    typedef enum logic [2:0] {
        PH_FIRST   = 3'd0,
        PH_SECOND  = 3'd1,
        PH_EXTLEN  = 3'd2,
        PH_MASK    = 3'd3,
        PH_PAYLOAD = 3'd4
    } phase_t;

    // 7-bit length code that announces a 16-bit extended length
    localparam logic [6:0] LEN7_EXT16 = 7'd126;

    // header byte counts
    localparam logic [3:0] EXT16_BYTES    = 4'd2;
    localparam logic [3:0] EXT64_BYTES    = 4'd8;
    localparam logic [3:0] MASK_KEY_BYTES = 4'd4;

    // one decoded result item
    typedef struct packed {
        logic       valid;
        logic [7:0] payload_byte;
        logic       frame_last;
        logic       frame_empty;
    } result_t;

endpackage

/* rtl/wsd_parser.sv */
// wsd_parser: frame header state machine and payload unmasking
// depends on wsd_pkg; one byte per cycle while byte_valid is high, result is combinational from state and byte
`timescale 1ns / 1ps

module wsd_parser #(
    parameter int LEN_BITS = 64
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             byte_valid,
    input  logic [7:0]       rx_byte,
    output wsd_pkg::result_t result
);
    import wsd_pkg::*;

    phase_t                phase_reg, phase_next;
    logic [3:0]            hdr_cnt_reg, hdr_cnt_next;
    logic [LEN_BITS-1:0]   remain_reg, remain_next;
    logic                  masked_reg, masked_next;
    logic [31:0]           key_reg, key_next;
    logic [1:0]            idx_reg, idx_next;

    logic                  len_done;
    logic                  hdr_done;
    logic [LEN_BITS-1:0]   len_value;
    logic                  masked_value;
    logic [3:0]            cnt_dec;
    logic [LEN_BITS-1:0]   remain_dec;
    logic [7:0]            key_byte;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_FIRST;
            hdr_cnt_reg <= '0;
            remain_reg  <= '0;
            masked_reg  <= 1'b0;
            key_reg     <= '0;
            idx_reg     <= '0;
        end else begin
            phase_reg   <= phase_next;
            hdr_cnt_reg <= hdr_cnt_next;
            remain_reg  <= remain_next;
            masked_reg  <= masked_next;
            key_reg     <= key_next;
            idx_reg     <= idx_next;
        end
    end

    assign cnt_dec    = hdr_cnt_reg - 4'd1;
    assign remain_dec = remain_reg - {{(LEN_BITS-1){1'b0}}, 1'b1};

    always_comb begin
        unique case (idx_reg)
            2'd0:    key_byte = key_reg[31:24];
            2'd1:    key_byte = key_reg[23:16];
            2'd2:    key_byte = key_reg[15:8];
            default: key_byte = key_reg[7:0];
        endcase
    end

    always_comb begin
        phase_next   = phase_reg;
        hdr_cnt_next = hdr_cnt_reg;
        remain_next  = remain_reg;
        masked_next  = masked_reg;
        key_next     = key_reg;
        idx_next     = idx_reg;
        result       = '0;
        len_done     = 1'b0;
        hdr_done     = 1'b0;
        len_value    = remain_reg;
        masked_value = masked_reg;

        if (byte_valid) begin
            unique case (phase_reg)
                PH_SECOND: begin
                    masked_value = rx_byte[7];
                    masked_next  = rx_byte[7];
                    if (rx_byte[6:0] < LEN7_EXT16) begin
                        len_value = {{(LEN_BITS-7){1'b0}}, rx_byte[6:0]};
                        len_done  = 1'b1;
                    end else begin
                        len_value    = '0;
                        phase_next   = PH_EXTLEN;
                        hdr_cnt_next = (rx_byte[6:0] == LEN7_EXT16) ? EXT16_BYTES
                                                                     : EXT64_BYTES;
                    end
                    remain_next = len_value;
                end
                PH_EXTLEN: begin
                    // big-endian, high bytes beyond LEN_BITS fall off
                    len_value    = {remain_reg[LEN_BITS-9:0], rx_byte};
                    remain_next  = len_value;
                    hdr_cnt_next = cnt_dec;
                    len_done     = (cnt_dec == 4'd0);
                end
                PH_MASK: begin
                    key_next     = {key_reg[23:0], rx_byte};
                    hdr_cnt_next = cnt_dec;
                    hdr_done     = (cnt_dec == 4'd0);
                end
                PH_PAYLOAD: begin
                    result.valid        = 1'b1;
                    result.payload_byte = masked_reg ? (rx_byte ^ key_byte) : rx_byte;
                    result.frame_last   = (remain_dec == '0);
                    idx_next            = idx_reg + 2'd1;
                    remain_next         = remain_dec;
                    if (remain_dec == '0) begin
                        phase_next = PH_FIRST;
                    end
                end
                default: begin
                    // first header byte and unused phase codes
                    phase_next   = PH_SECOND;
                    hdr_cnt_next = '0;
                end
            endcase

            // length complete: fetch the mask key or finish the header
            if (len_done) begin
                if (masked_value) begin
                    phase_next   = PH_MASK;
                    hdr_cnt_next = MASK_KEY_BYTES;
                    key_next     = '0;
                end else begin
                    hdr_done = 1'b1;
                end
            end

            if (hdr_done) begin
                idx_next = '0;
                if (len_value == '0) begin
                    phase_next         = PH_FIRST;
                    result.valid       = 1'b1;
                    result.frame_last  = 1'b1;
                    result.frame_empty = 1'b1;
                end else begin
                    phase_next = PH_PAYLOAD;
                end
            end
        end
    end

endmodule

/* rtl/wsd_out_reg.sv */
// wsd_out_reg: result register on the m_ side
// depends on wsd_pkg; holds one item until the receiver takes it
`timescale 1ns / 1ps

module wsd_out_reg (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             load,
    input  wsd_pkg::result_t result,
    input  logic             m_ready,
    output logic             free,
    output logic             m_valid,
    output logic [7:0]       m_payload_byte,
    output logic             m_frame_last,
    output logic             m_frame_empty
);
    import wsd_pkg::*;

    logic       valid_reg;
    logic [7:0] byte_reg;
    logic       last_reg;
    logic       empty_reg;

    assign free = !valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (free) begin
            valid_reg <= load && result.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (free && load && result.valid) begin
            byte_reg  <= result.payload_byte;
            last_reg  <= result.frame_last;
            empty_reg <= result.frame_empty;
        end
    end

    assign m_valid        = valid_reg;
    assign m_payload_byte = byte_reg;
    assign m_frame_last   = last_reg;
    assign m_frame_empty  = empty_reg;

endmodule

/* rtl/websocket_frame_decoder.sv */
// websocket_frame_decoder: top level of the receive frame decoder
// depends on wsd_pkg, wsd_parser and wsd_out_reg
`timescale 1ns / 1ps

// usage
//   s_ channel: one received stream byte per item on s_rx_byte, taken after the
//   opening handshake; header bytes are consumed silently
//   m_ channel: one item per payload byte (unmasked, last byte flagged with
//   m_frame_last), or a single item with m_frame_empty set for a zero-length frame
//   path: a byte is registered on acceptance in the input register, parsed
//   from there and its item registered in the result register that drives m_valid
//   throughput: one byte per cycle while m_ready takes every item; the only loop
//   is the parse state update (length counter decrement and zero compare)
//   stall: while the result register holds an item that m_ready refuses, the
//   parse stage waits and s_ready drops once the input register is full too;
//   nothing is lost or repeated
//   reset: synchronous active-low aresetn returns the parser to waiting for the
//   first header byte and empties both registers; no clearing pass
//   LEN_BITS sets the width of the payload length counter (16 to 64); longer
//   extended lengths keep their low LEN_BITS bits
module websocket_frame_decoder #(
    parameter int LEN_BITS = 64
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_rx_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_payload_byte,
    output logic       m_frame_last,
    output logic       m_frame_empty
);
    import wsd_pkg::*;

    // input register
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;

    logic       out_free;
    logic       advance;
    result_t    result;

    // the parse stage moves only when the result register can take its item
    assign advance = in_valid_reg && out_free;
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_byte_reg <= s_rx_byte;
        end
    end

    // header state machine and unmasking
    wsd_parser #(
        .LEN_BITS (LEN_BITS)
    ) u_parser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .byte_valid (advance),
        .rx_byte    (in_byte_reg),
        .result     (result)
    );

    // result register
    wsd_out_reg u_out_reg (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .load           (advance),
        .result         (result),
        .m_ready        (m_ready),
        .free           (out_free),
        .m_valid        (m_valid),
        .m_payload_byte (m_payload_byte),
        .m_frame_last   (m_frame_last),
        .m_frame_empty  (m_frame_empty)
    );

endmodule
